### sv/rhg_pkg.sv
// rhg_pkg: shared constants, codes and helpers for the heading guidance block
// no dependencies; used by the cordic units and the top level
package rhg_pkg;

  localparam int CORDIC_STAGES_DEFAULT = 16;
  localparam int MAX_STAGES = 24;

  // angle accumulator: 2^31 is pi, with headroom for the table sum
  localparam int ZW = 34;
  // rotation datapath (q30 cos/sin) and vectoring datapath widths
  localparam int ROT_W = 32;
  localparam int VEC_W = 30;
  localparam int VEC_IN_W = 19;

  localparam int SQ1_IN_W = 54;
  localparam int SQ2_IN_W = 36;

  localparam logic signed [ROT_W-1:0] CORDIC_X0 = 32'sd652032874;
  localparam logic [33:0] ARRIVE_DIST2 = 34'd26844;
  localparam logic signed [22:0] PI_Q20 = 23'sd3294199;

  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_POSITION = 3'd1,
    MODE_VECTOR   = 3'd2,
    MODE_FIELD    = 3'd3,
    MODE_ORIENT   = 3'd4,
    MODE_VELOCITY = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE           = 3'd0,
    REG_GOAL_X         = 3'd1,
    REG_GOAL_Y         = 3'd2,
    REG_GOAL_HEADING   = 3'd3,
    REG_GOAL_SPEED     = 3'd4,
    REG_GOAL_TURN_RATE = 3'd5,
    REG_FIELD_REF_DIST = 3'd6,
    REG_FIELD_GAIN     = 3'd7
  } reg_index_t;

  // atan(2^-i) with 2^31 equal to pi
  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933405;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335086;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41721;
      15: r = 34'sd20860;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2607;
      19: r = 34'sd1303;
      20: r = 34'sd651;
      21: r = 34'sd325;
      22: r = 34'sd162;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### sv/rhg_delay.sv
// rhg_delay: fixed-length register line that keeps side data aligned with the
// pipelined units; no package dependency
module rhg_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  generate
    if (DEPTH == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [WIDTH-1:0] sr [0:DEPTH-1];
      always_ff @(posedge clk) begin
        if (rst) begin
          for (int i = 0; i < DEPTH; i++) sr[i] <= '0;
        end else begin
          sr[0] <= d;
          for (int i = 1; i < DEPTH; i++) sr[i] <= sr[i-1];
        end
      end
      assign q = sr[DEPTH-1];
    end
  endgenerate

endmodule

### sv/rhg_isqrt.sv
// rhg_isqrt: pipelined floor square root, one result bit per stage;
// no package dependency
module rhg_isqrt #(
  parameter int IN_W = 54
) (
  input  logic              clk,
  input  logic [IN_W-1:0]   rad,
  output logic [IN_W/2-1:0] root
);

  localparam int OUT_W = IN_W / 2;
  localparam int RW = OUT_W + 2;

  logic [RW-1:0]    rem  [1:OUT_W];
  logic [OUT_W-1:0] q    [1:OUT_W];
  logic [IN_W-1:0]  rest [1:OUT_W-1];

  generate
    for (genvar k = 0; k < OUT_W; k++) begin : g_bit
      logic [RW-1:0]    r_in;
      logic [OUT_W-1:0] q_in;
      logic [1:0]       pair;
      logic [RW+1:0]    shifted;
      logic [RW+1:0]    trial;
      logic [RW+1:0]    diff;
      logic             ge;

      if (k == 0) begin : g_first
        assign r_in = '0;
        assign q_in = '0;
        assign pair = rad[IN_W-1 -: 2];
      end else begin : g_next
        assign r_in = rem[k];
        assign q_in = q[k];
        assign pair = rest[k][IN_W-1 -: 2];
      end

      always_comb begin
        shifted = {r_in, pair};
        trial   = {2'b00, q_in, 2'b01};
        ge      = shifted >= trial;
        diff    = shifted - trial;
      end

      always_ff @(posedge clk) begin
        rem[k+1] <= ge ? diff[RW-1:0] : shifted[RW-1:0];
        q[k+1]   <= {q_in[OUT_W-2:0], ge};
      end

      if (k < OUT_W - 1) begin : g_rest
        if (k == 0) begin : g_rest_first
          always_ff @(posedge clk) rest[k+1] <= {rad[IN_W-3:0], 2'b00};
        end else begin : g_rest_next
          always_ff @(posedge clk) rest[k+1] <= {rest[k][IN_W-3:0], 2'b00};
        end
      end
    end
  endgenerate

  assign root = q[OUT_W];

endmodule

### sv/rhg_cordic_rot.sv
// rhg_cordic_rot: pipelined rotation cordic, cos and sin of a binary angle in q30
// depends on rhg_pkg
module rhg_cordic_rot #(
  parameter int STAGES = rhg_pkg::CORDIC_STAGES_DEFAULT
) (
  input  logic                             clk,
  input  logic signed [15:0]               angle,
  output logic signed [rhg_pkg::ROT_W-1:0] cos_q,
  output logic signed [rhg_pkg::ROT_W-1:0] sin_q
);

  localparam int ZW = rhg_pkg::ZW;
  localparam int RW = rhg_pkg::ROT_W;

  logic signed [RW-1:0] x [0:STAGES];
  logic signed [RW-1:0] y [0:STAGES];
  logic signed [ZW-1:0] z [0:STAGES];
  logic                 flip [0:STAGES];

  logic signed [15:0] a_fold;
  logic               a_flip;

  // fold the back half plane onto the front half and negate at the end
  always_comb begin
    a_flip = (angle > 16'sd16384) || (angle < -16'sd16384);
    a_fold = a_flip ? {~angle[15], angle[14:0]} : angle;
  end

  always_ff @(posedge clk) begin
    x[0]    <= rhg_pkg::CORDIC_X0;
    y[0]    <= '0;
    z[0]    <= {{(ZW-32){a_fold[15]}}, a_fold, 16'h0000};
    flip[0] <= a_flip;
  end

  generate
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
      always_ff @(posedge clk) begin
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - rhg_pkg::atan_entry(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + rhg_pkg::atan_entry(i);
        end
        flip[i+1] <= flip[i];
      end
    end
  endgenerate

  assign cos_q = flip[STAGES] ? -x[STAGES] : x[STAGES];
  assign sin_q = flip[STAGES] ? -y[STAGES] : y[STAGES];

endmodule

### sv/rhg_cordic_vec.sv
// rhg_cordic_vec: pipelined vectoring cordic, bearing of (dx, dy) as a binary angle
// depends on rhg_pkg
module rhg_cordic_vec #(
  parameter int STAGES = rhg_pkg::CORDIC_STAGES_DEFAULT
) (
  input  logic                                clk,
  input  logic signed [rhg_pkg::VEC_IN_W-1:0] dx,
  input  logic signed [rhg_pkg::VEC_IN_W-1:0] dy,
  output logic signed [15:0]                  angle
);

  localparam int ZW = rhg_pkg::ZW;
  localparam int W = rhg_pkg::VEC_W;
  localparam int IW = rhg_pkg::VEC_IN_W;

  logic signed [W-1:0]  x [0:STAGES];
  logic signed [W-1:0]  y [0:STAGES];
  logic signed [ZW-1:0] z [0:STAGES];
  logic                 zero [0:STAGES];

  logic signed [W-1:0]  xs;
  logic signed [W-1:0]  ys;
  logic signed [W-1:0]  x_pre;
  logic signed [W-1:0]  y_pre;
  logic signed [ZW-1:0] z_pre;
  logic signed [ZW-1:0] z_rnd;

  // inputs scaled by 256, left half plane turned by a quarter first
  always_comb begin
    xs = {{(W-IW-8){dx[IW-1]}}, dx, 8'h00};
    ys = {{(W-IW-8){dy[IW-1]}}, dy, 8'h00};
    x_pre = xs;
    y_pre = ys;
    z_pre = '0;
    if (xs[W-1]) begin
      if (!ys[W-1]) begin
        x_pre = ys;
        y_pre = -xs;
        z_pre = 34'sd1073741824;
      end else begin
        x_pre = -ys;
        y_pre = xs;
        z_pre = -34'sd1073741824;
      end
    end
  end

  always_ff @(posedge clk) begin
    x[0]    <= x_pre;
    y[0]    <= y_pre;
    z[0]    <= z_pre;
    zero[0] <= (dx == '0) && (dy == '0);
  end

  generate
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
      always_ff @(posedge clk) begin
        if (!y[i][W-1]) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + rhg_pkg::atan_entry(i);
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - rhg_pkg::atan_entry(i);
        end
        zero[i+1] <= zero[i];
      end
    end
  endgenerate

  // round half up to 16 bits; the robot on the target reads as angle 0
  assign z_rnd = z[STAGES] + 34'sd32768;
  assign angle = zero[STAGES] ? 16'sd0 : z_rnd[31:16];

endmodule

### sv/robot_heading_guidance.sv
// robot_heading_guidance: top level, registers, mode select and steering law
// depends on rhg_pkg, rhg_delay, rhg_isqrt, rhg_cordic_rot, rhg_cordic_vec
//
// Usage:
//   A pose word (pose_x, pose_y, pose_heading) is taken at every rising edge
//   with start high; busy is always low, so a pose can enter every cycle.
//   Each pose gives exactly one result word (linear_speed, turn_rate,
//   reversing, arrived), shown for one cycle with done high. Results leave
//   in the order the poses came in; the receiver cannot hold them off.
//   The join waits on the longer of the position path (two pipelined square
//   roots, 27 and 18 stages) and the field path (rotation cordic, then
//   vectoring cordic). Throughput is one word per cycle.
//   Goal registers are written through cfg_write/cfg_index/cfg_data and
//   must only change while no pose is in flight.
//   Reset (rst, synchronous) loads the register defaults and drops every
//   word in flight; no done follows for poses taken before reset.
module robot_heading_guidance #(
  parameter int CORDIC_STAGES = rhg_pkg::CORDIC_STAGES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] pose_x,
  input  logic signed [15:0] pose_y,
  input  logic signed [15:0] pose_heading,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic signed [15:0] linear_speed,
  output logic signed [15:0] turn_rate,
  output logic               reversing,
  output logic               arrived
);

  localparam int N = CORDIC_STAGES;
  localparam int LAT = N + 1;
  localparam int L2 = 2 * LAT + 2;
  localparam int SQ1_OUT = rhg_pkg::SQ1_IN_W / 2;
  localparam int SQ2_OUT = rhg_pkg::SQ2_IN_W / 2;
  localparam int L3 = 2 + SQ1_OUT + SQ2_OUT + 2;
  localparam int J = (L2 > L3) ? L2 : L3;
  localparam int TOTAL = J + N + 7;
  localparam int RW = rhg_pkg::ROT_W;
  localparam int IW = rhg_pkg::VEC_IN_W;

  // configuration registers
  logic [2:0]         mode;
  logic signed [15:0] goal_x;
  logic signed [15:0] goal_y;
  logic signed [15:0] goal_heading;
  logic signed [15:0] goal_speed;
  logic signed [15:0] goal_turn_rate;
  logic [13:0]        field_ref_distance;
  logic [9:0]         field_gain;

  // input stage and differences
  logic               s0_valid;
  logic signed [15:0] s0_px;
  logic signed [15:0] s0_py;
  logic signed [15:0] s0_ph;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [IW-1:0] dx_ext;
  logic signed [IW-1:0] dy_ext;

  // position path
  logic [33:0]          sqx;
  logic [33:0]          sqy;
  logic [33:0]          d2;
  logic [SQ1_OUT-1:0]   root1;
  logic [SQ2_OUT-1:0]   root2;
  logic signed [34:0]   vprod;
  logic signed [34:0]   vprod_rnd;
  logic signed [18:0]   v_pos;

  // field reference path
  logic signed [RW-1:0] gc;
  logic signed [RW-1:0] gs;
  logic signed [46:0]   pc;
  logic signed [46:0]   ps;
  logic signed [46:0]   pc_rnd;
  logic signed [46:0]   ps_rnd;
  logic [16:0]          dx_d;
  logic [16:0]          dy_d;
  logic signed [IW-1:0] rdx;
  logic signed [IW-1:0] rdy;

  // join
  logic signed [15:0] to_t_raw;
  logic signed [15:0] to_r_raw;
  logic [15:0]        to_t_j;
  logic [15:0]        to_r_j;
  logic [18:0]        v_j;
  logic [15:0]        ph_j;
  logic signed [15:0] fi;

  // steering stages
  logic signed [26:0] e1_gf;
  logic signed [15:0] e1_to_t;
  logic signed [15:0] e1_ph;
  logic signed [18:0] e1_v;
  logic signed [26:0] gf_rnd;
  logic signed [15:0] th_field;
  logic signed [15:0] e2_theta;
  logic signed [15:0] e2_ph;
  logic signed [18:0] e2_v;
  logic signed [15:0] err;
  logic               err_back;
  logic signed [15:0] e3_e;
  logic               e3_back;
  logic signed [18:0] e3_v;

  // speed and turn products
  logic signed [RW-1:0] c3;
  logic signed [RW-1:0] s3;
  logic [18:0]          v_c;
  logic                 back_f;
  logic signed [50:0]   p;
  logic signed [51:0]   pn;
  logic signed [51:0]   pr;
  logic signed [15:0]   ls_steer;
  logic signed [19:0]   t1;
  logic signed [42:0]   t2;
  logic signed [42:0]   t2_rnd;
  logic signed [15:0]   t3;
  logic [15:0]          tr_f;
  logic                 arr_k2;
  logic                 arr_f;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= rhg_pkg::MODE_NONE;
      goal_x             <= '0;
      goal_y             <= '0;
      goal_heading       <= '0;
      goal_speed         <= '0;
      goal_turn_rate     <= '0;
      field_ref_distance <= '0;
      field_gain         <= 10'd256;
    end else if (cfg_write) begin
      unique case (rhg_pkg::reg_index_t'(cfg_index))
        rhg_pkg::REG_MODE:           mode <= cfg_data[2:0];
        rhg_pkg::REG_GOAL_X:         goal_x <= cfg_data;
        rhg_pkg::REG_GOAL_Y:         goal_y <= cfg_data;
        rhg_pkg::REG_GOAL_HEADING:   goal_heading <= cfg_data;
        rhg_pkg::REG_GOAL_SPEED:     goal_speed <= cfg_data;
        rhg_pkg::REG_GOAL_TURN_RATE: goal_turn_rate <= cfg_data;
        rhg_pkg::REG_FIELD_REF_DIST: field_ref_distance <= cfg_data[13:0];
        rhg_pkg::REG_FIELD_GAIN:     field_gain <= cfg_data[9:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_px <= pose_x;
    s0_py <= pose_y;
    s0_ph <= pose_heading;
    dx    <= {goal_x[15], goal_x} - {s0_px[15], s0_px};
    dy    <= {goal_y[15], goal_y} - {s0_py[15], s0_py};
  end

  assign dx_ext = {{(IW-17){dx[16]}}, dx};
  assign dy_ext = {{(IW-17){dy[16]}}, dy};

  // ---- position path: squared distance, then sqrt(sqrt(d2 << 20) << 9)
  always_ff @(posedge clk) begin
    sqx <= dx * dx;
    sqy <= dy * dy;
    d2  <= sqx + sqy;
  end

  assign arr_k2 = d2 < rhg_pkg::ARRIVE_DIST2;

  rhg_isqrt #(.IN_W(rhg_pkg::SQ1_IN_W)) u_sqrt_dist (
    .clk  (clk),
    .rad  ({d2, 20'h00000}),
    .root (root1)
  );

  rhg_isqrt #(.IN_W(rhg_pkg::SQ2_IN_W)) u_sqrt_root (
    .clk  (clk),
    .rad  ({root1, 9'h000}),
    .root (root2)
  );

  assign vprod_rnd = vprod + 35'sd32768;

  always_ff @(posedge clk) begin
    vprod <= goal_speed * $signed({1'b0, root2});
    v_pos <= vprod_rnd[34:16];
  end

  // ---- field path: reference point ahead of the target, then its bearing
  rhg_cordic_rot #(.STAGES(N)) u_rot_goal (
    .clk   (clk),
    .angle (goal_heading),
    .cos_q (gc),
    .sin_q (gs)
  );

  rhg_delay #(.WIDTH(17), .DEPTH(LAT + 1)) u_dly_dx (
    .clk (clk), .rst (rst), .d (dx), .q (dx_d)
  );

  rhg_delay #(.WIDTH(17), .DEPTH(LAT + 1)) u_dly_dy (
    .clk (clk), .rst (rst), .d (dy), .q (dy_d)
  );

  assign pc_rnd = pc + 47'sd536870912;
  assign ps_rnd = ps + 47'sd536870912;

  always_ff @(posedge clk) begin
    pc  <= $signed({1'b0, field_ref_distance}) * gc;
    ps  <= $signed({1'b0, field_ref_distance}) * gs;
    rdx <= $signed({{(IW-17){dx_d[16]}}, dx_d}) + $signed({{(IW-17){pc_rnd[46]}}, pc_rnd[46:30]});
    rdy <= $signed({{(IW-17){dy_d[16]}}, dy_d}) + $signed({{(IW-17){ps_rnd[46]}}, ps_rnd[46:30]});
  end

  rhg_cordic_vec #(.STAGES(N)) u_vec_target (
    .clk   (clk),
    .dx    (dx_ext),
    .dy    (dy_ext),
    .angle (to_t_raw)
  );

  rhg_cordic_vec #(.STAGES(N)) u_vec_ref (
    .clk   (clk),
    .dx    (rdx),
    .dy    (rdy),
    .angle (to_r_raw)
  );

  // ---- align all paths at the join
  rhg_delay #(.WIDTH(16), .DEPTH(J - LAT)) u_dly_to_t (
    .clk (clk), .rst (rst), .d (to_t_raw), .q (to_t_j)
  );

  rhg_delay #(.WIDTH(16), .DEPTH(J - L2)) u_dly_to_r (
    .clk (clk), .rst (rst), .d (to_r_raw), .q (to_r_j)
  );

  rhg_delay #(.WIDTH(19), .DEPTH(J - L3)) u_dly_v (
    .clk (clk), .rst (rst), .d (v_pos), .q (v_j)
  );

  rhg_delay #(.WIDTH(16), .DEPTH(J + 1)) u_dly_ph (
    .clk (clk), .rst (rst), .d (s0_ph), .q (ph_j)
  );

  rhg_delay #(.WIDTH(1), .DEPTH(J + N + 3)) u_dly_arr (
    .clk (clk), .rst (rst), .d (arr_k2), .q (arr_f)
  );

  // ---- steering: target bearing per mode, heading error, direction
  assign fi = to_r_j - to_t_j;

  always_ff @(posedge clk) begin
    e1_gf   <= $signed({1'b0, field_gain}) * fi;
    e1_to_t <= to_t_j;
    e1_ph   <= ph_j;
    if (mode == rhg_pkg::MODE_POSITION) begin
      e1_v <= v_j;
    end else if (mode == rhg_pkg::MODE_VECTOR || mode == rhg_pkg::MODE_FIELD) begin
      e1_v <= {{3{goal_speed[15]}}, goal_speed};
    end else begin
      e1_v <= '0;
    end
  end

  assign gf_rnd   = e1_gf + 27'sd128;
  assign th_field = e1_to_t - gf_rnd[23:8];

  always_ff @(posedge clk) begin
    e2_ph <= e1_ph;
    e2_v  <= e1_v;
    unique case (rhg_pkg::mode_t'(mode))
      rhg_pkg::MODE_POSITION: e2_theta <= e1_to_t;
      rhg_pkg::MODE_FIELD:    e2_theta <= th_field;
      default:                e2_theta <= goal_heading;
    endcase
  end

  // error beyond a quarter turn either way: drive backwards on the opposite heading
  always_comb begin
    err      = e2_theta - e2_ph;
    err_back = (err > 16'sd16384) || (err < -16'sd16384);
  end

  always_ff @(posedge clk) begin
    e3_e    <= err_back ? {~err[15], err[14:0]} : err;
    e3_back <= err_back;
    e3_v    <= e2_v;
  end

  rhg_cordic_rot #(.STAGES(N)) u_rot_err (
    .clk   (clk),
    .angle (e3_e),
    .cos_q (c3),
    .sin_q (s3)
  );

  rhg_delay #(.WIDTH(19), .DEPTH(LAT)) u_dly_vc (
    .clk (clk), .rst (rst), .d (e3_v), .q (v_c)
  );

  rhg_delay #(.WIDTH(1), .DEPTH(LAT + 1)) u_dly_back (
    .clk (clk), .rst (rst), .d (e3_back), .q (back_f)
  );

  always_ff @(posedge clk) begin
    p <= $signed(v_c) * c3;
  end

  // negate before rounding, as rounding is half up
  always_comb begin
    pn       = back_f ? -$signed({p[50], p}) : $signed({p[50], p});
    pr       = pn + 52'sd536870912;
    ls_steer = rhg_pkg::sat16({{2{pr[51]}}, pr[51:30]});
  end

  // turn: gain 10 backwards, 15 forwards, times error times pi/64
  assign t2_rnd = t2 + 43'sd33554432;

  always_ff @(posedge clk) begin
    if (e3_back) begin
      t1 <= ({{4{e3_e[15]}}, e3_e} <<< 3) + ({{4{e3_e[15]}}, e3_e} <<< 1);
    end else begin
      t1 <= ({{4{e3_e[15]}}, e3_e} <<< 4) - {{4{e3_e[15]}}, e3_e};
    end
    t2 <= t1 * rhg_pkg::PI_Q20;
    t3 <= rhg_pkg::sat16({{7{t2_rnd[42]}}, t2_rnd[42:26]});
  end

  rhg_delay #(.WIDTH(16), .DEPTH(N - 1)) u_dly_turn (
    .clk (clk), .rst (rst), .d (t3), .q (tr_f)
  );

  // ---- result word
  always_ff @(posedge clk) begin
    linear_speed <= '0;
    turn_rate    <= '0;
    reversing    <= 1'b0;
    arrived      <= 1'b0;
    unique case (rhg_pkg::mode_t'(mode))
      rhg_pkg::MODE_POSITION: begin
        if (arr_f) begin
          arrived <= 1'b1;
        end else begin
          linear_speed <= ls_steer;
          turn_rate    <= tr_f;
          reversing    <= back_f;
        end
      end
      rhg_pkg::MODE_VECTOR, rhg_pkg::MODE_FIELD, rhg_pkg::MODE_ORIENT: begin
        linear_speed <= ls_steer;
        turn_rate    <= tr_f;
        reversing    <= back_f;
      end
      rhg_pkg::MODE_VELOCITY: begin
        linear_speed <= goal_speed;
        turn_rate    <= goal_turn_rate;
      end
      default: begin
        linear_speed <= '0;
      end
    endcase
  end

  rhg_delay #(.WIDTH(1), .DEPTH(TOTAL)) u_dly_valid (
    .clk (clk), .rst (rst), .d (s0_valid), .q (done)
  );

`ifndef SYNTH
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    done && ($past(mode) == rhg_pkg::MODE_NONE) |->
      (linear_speed == 16'sd0) && (turn_rate == 16'sd0) && !reversing && !arrived)
    else $error("mode none gave a nonzero result word");

  a_arrived_still: assert property (@(posedge clk) disable iff (rst)
    done && arrived |-> !reversing && (linear_speed == 16'sd0) && (turn_rate == 16'sd0)
      && ($past(mode) == rhg_pkg::MODE_POSITION))
    else $error("arrived word carries motion or wrong mode");

  a_reverse_mode: assert property (@(posedge clk) disable iff (rst)
    done && reversing |->
      ($past(mode) == rhg_pkg::MODE_POSITION) || ($past(mode) == rhg_pkg::MODE_VECTOR) ||
      ($past(mode) == rhg_pkg::MODE_FIELD) || ($past(mode) == rhg_pkg::MODE_ORIENT))
    else $error("reversing set outside a steering mode");
`endif

endmodule
